FILE: hdl/i2c_eeprom_byte_master_macros.svh
// Assertion macros shared by the I2C EEPROM byte master RTL
`ifndef I2C_EEPROM_BYTE_MASTER_MACROS_SVH
`define I2C_EEPROM_BYTE_MASTER_MACROS_SVH

// same-cycle implication, held off during reset
`define I2CEE_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define I2CEE_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hdl/i2cee_pkg.sv
// Shared types and constants of the I2C EEPROM byte master
package i2cee_pkg;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_QUARTER_TICKS  = 2'd1;
  localparam logic [1:0] REG_WRITE_WAIT     = 2'd2;

  localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd87;
  localparam logic [15:0] QUARTER_TICKS_RST  = 16'd25;
  localparam logic [19:0] WRITE_WAIT_RST     = 20'd20000;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_WRITE,
    KIND_READ
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] mem_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] quarter_period_ticks;
    logic [19:0] write_wait_quarters;
  } cfg_t;

  typedef struct packed {
    logic       nack_seen;
    logic       done_res;
    logic [7:0] read_data;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } res_t;

endpackage

FILE: hdl/i2c_eeprom_byte_master.sv
// Top level of the I2C EEPROM byte master: register port, tick queue and bus engine
//
//   channel   | direction | handshake                  | contents
//   s_axis    | in        | tvalid/tready              | tuser cmd, tdata tick item
//   m_axis    | out       | tvalid/tready              | tdata line levels and status
//   apb       | in        | psel/penable, pready high  | three registers at 0x0, 0x4, 0x8
//
// One beat in and one beat out per cycle sustained while m_axis_tready stays high; the bus engine steps once per beat.
// An input beat passes through the queue and then the result register on its way to the output.
// Reset clears the queue, the engine state and the registers to their defaults.
// A stalled output holds its beat while the queue takes up to QUEUE_DEPTH more beats.
module i2c_eeprom_byte_master
  import i2cee_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  input  logic [23:0] s_axis_tdata,  // mem_addr[7:0], write_data[15:8], sda_in[16], zero[23:17]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // scl_out[0], sda_out[1], busy_res[2], read_data[10:3],
                                     // done_res[11], nack_seen[12], zero[15:13]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg_q;
  item_t item;
  logic  item_valid, item_ready;
  res_t  res;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address       <= DEVICE_ADDRESS_RST;
      cfg_q.quarter_period_ticks <= QUARTER_TICKS_RST;
      cfg_q.write_wait_quarters  <= WRITE_WAIT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_DEVICE_ADDRESS: cfg_q.device_address       <= pwdata[6:0];
        REG_QUARTER_TICKS:  cfg_q.quarter_period_ticks <= pwdata[15:0];
        REG_WRITE_WAIT:     cfg_q.write_wait_quarters  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEVICE_ADDRESS: prdata = {25'd0, cfg_q.device_address};
      REG_QUARTER_TICKS:  prdata = {16'd0, cfg_q.quarter_period_ticks};
      REG_WRITE_WAIT:     prdata = {12'd0, cfg_q.write_wait_quarters};
      default:            prdata = '0;
    endcase
  end

  i2cee_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_ready_i  (item_ready)
  );

  i2cee_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (m_axis_tvalid),
    .res_o        (res),
    .res_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {3'd0, res};

endmodule

FILE: hdl/i2cee_front.sv
// Input side: decode tick beats and queue them for the bus engine
`include "i2c_eeprom_byte_master_macros.svh"

module i2cee_front
  import i2cee_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,
  input  logic [23:0] s_axis_tdata,
  output logic        item_valid_o,
  output item_t       item_o,
  input  logic        item_ready_i
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  item_t            item_in;
  logic             push, pop;

  always_comb begin
    unique case (s_axis_tuser)
      CMD_WRITE: item_in.kind = KIND_WRITE;
      CMD_READ:  item_in.kind = KIND_READ;
      default:   item_in.kind = KIND_NONE;
    endcase
    item_in.mem_addr   = s_axis_tdata[7:0];
    item_in.write_data = s_axis_tdata[15:8];
    item_in.sda_in     = s_axis_tdata[16];
  end

  assign s_axis_tready = (count_q != CNT_W'(DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid_o  = (count_q != '0);
  assign pop           = item_valid_o && item_ready_i;
  assign item_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  `I2CEE_ASSERT_NXT(a_count_tracks, clk_i, rst_ni, push && !pop, count_q == $past(count_q) + CNT_W'(1), "queue count lost a push")

endmodule

FILE: hdl/i2cee_engine.sv
// Bus engine: one tick per beat, drives SCL and SDA and registers the result
`include "i2c_eeprom_byte_master_macros.svh"

module i2cee_engine
  import i2cee_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  item_valid_i,
  output logic  item_ready_o,
  input  item_t item_i,
  output logic  res_valid_o,
  output res_t  res_o,
  input  logic  res_ready_i
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_SEND_DEVW,
    PH_ACK_DEVW,
    PH_SEND_MEM,
    PH_ACK_MEM,
    PH_SEND_DATA,
    PH_ACK_DATA,
    PH_RESTART,
    PH_SEND_DEVR,
    PH_ACK_DEVR,
    PH_READ,
    PH_NOACK,
    PH_STOP,
    PH_WAIT
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  quarter_q, quarter_d;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [19:0] wait_q, wait_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  data_q, data_d;
  logic        is_read_q, is_read_d;
  logic        nack_q, nack_d;
  logic [7:0]  last_q, last_d;
  logic        res_valid_q;
  res_t        res_q, res_d;
  logic        pop;

  assign item_ready_o = !res_valid_q || res_ready_i;
  assign pop          = item_valid_i && item_ready_o;
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  always_comb begin
    logic [15:0] period;
    logic [3:0]  bit_inc;
    logic        scl, sda, done;

    phase_d   = phase_q;
    quarter_d = quarter_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    wait_d    = wait_q;
    addr_d    = addr_q;
    data_d    = data_q;
    is_read_d = is_read_q;
    nack_d    = nack_q;
    last_d    = last_q;
    done      = 1'b0;
    period    = (cfg_i.quarter_period_ticks == '0) ? 16'd1 : cfg_i.quarter_period_ticks;
    bit_inc   = bit_q + 4'd1;

    if (phase_q == PH_IDLE && item_i.kind != KIND_NONE) begin
      addr_d    = item_i.mem_addr;
      data_d    = item_i.write_data;
      is_read_d = (item_i.kind == KIND_READ);
      nack_d    = 1'b0;
      phase_d   = PH_START;
      quarter_d = 2'd0;
      tick_d    = '0;
      bit_d     = '0;
      bit_inc   = 4'd1;
    end

    unique case (phase_d)
      PH_IDLE, PH_WAIT: begin
        scl = 1'b1;
        sda = 1'b1;
      end
      PH_START: begin
        scl = (quarter_d != 2'd3);
        sda = (quarter_d < 2'd2);
      end
      PH_RESTART: begin
        scl = (quarter_d == 2'd1) || (quarter_d == 2'd2);
        sda = (quarter_d < 2'd2);
      end
      PH_STOP: begin
        scl = (quarter_d != 2'd0);
        sda = (quarter_d >= 2'd2);
      end
      PH_SEND_DEVW, PH_SEND_MEM, PH_SEND_DATA, PH_SEND_DEVR: begin
        scl = (quarter_d == 2'd1) || (quarter_d == 2'd2);
        sda = shift_q[7];
      end
      default: begin
        scl = (quarter_d == 2'd1) || (quarter_d == 2'd2);
        sda = 1'b1;
      end
    endcase

    if (phase_d != PH_IDLE) begin
      if ({1'b0, tick_d} + 17'd1 >= {1'b0, period}) begin
        tick_d = '0;
        if (phase_d == PH_WAIT) begin
          wait_d = wait_q - 20'd1;
          if (wait_d == '0) begin
            phase_d   = PH_IDLE;
            quarter_d = 2'd0;
            done      = 1'b1;
          end
        end else begin
          if (quarter_d == 2'd2) begin
            unique case (phase_d)
              PH_ACK_DEVW, PH_ACK_MEM, PH_ACK_DATA, PH_ACK_DEVR: begin
                nack_d = nack_d | item_i.sda_in;
              end
              PH_READ: shift_d = {shift_q[6:0], item_i.sda_in};
              default: ;
            endcase
          end
          if (quarter_d != 2'd3) begin
            quarter_d = quarter_d + 2'd1;
          end else begin
            quarter_d = 2'd0;
            unique case (phase_d)
              PH_START: begin
                phase_d = PH_SEND_DEVW;
                shift_d = {cfg_i.device_address, 1'b0};
                bit_d   = '0;
              end
              PH_SEND_DEVW, PH_SEND_MEM, PH_SEND_DATA, PH_SEND_DEVR: begin
                shift_d = {shift_q[6:0], 1'b0};
                if (bit_inc >= 4'd8) begin
                  bit_d = '0;
                  unique case (phase_d)
                    PH_SEND_DEVW: phase_d = PH_ACK_DEVW;
                    PH_SEND_MEM:  phase_d = PH_ACK_MEM;
                    PH_SEND_DATA: phase_d = PH_ACK_DATA;
                    default:      phase_d = PH_ACK_DEVR;
                  endcase
                end else begin
                  bit_d = bit_inc;
                end
              end
              PH_ACK_DEVW: begin
                phase_d = PH_SEND_MEM;
                shift_d = addr_d;
                bit_d   = '0;
              end
              PH_ACK_MEM: begin
                if (is_read_d) begin
                  phase_d = PH_RESTART;
                end else begin
                  phase_d = PH_SEND_DATA;
                  shift_d = data_d;
                  bit_d   = '0;
                end
              end
              PH_ACK_DATA: phase_d = PH_STOP;
              PH_RESTART: begin
                phase_d = PH_SEND_DEVR;
                shift_d = {cfg_i.device_address, 1'b1};
                bit_d   = '0;
              end
              PH_ACK_DEVR: begin
                phase_d = PH_READ;
                shift_d = '0;
                bit_d   = '0;
              end
              PH_READ: begin
                if (bit_inc >= 4'd8) begin
                  bit_d   = '0;
                  phase_d = PH_NOACK;
                end else begin
                  bit_d = bit_inc;
                end
              end
              PH_NOACK: phase_d = PH_STOP;
              PH_STOP: begin
                if (is_read_d) begin
                  last_d  = shift_d;
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else if (cfg_i.write_wait_quarters == '0) begin
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  wait_d  = cfg_i.write_wait_quarters;
                  phase_d = PH_WAIT;
                end
              end
              default: begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
            endcase
          end
        end
      end else begin
        tick_d = tick_d + 16'd1;
      end
    end

    res_d.scl_out   = scl;
    res_d.sda_out   = sda;
    res_d.busy_res  = (phase_d != PH_IDLE);
    res_d.read_data = last_d;
    res_d.done_res  = done;
    res_d.nack_seen = nack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      quarter_q   <= '0;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      wait_q      <= '0;
      addr_q      <= '0;
      data_q      <= '0;
      is_read_q   <= 1'b0;
      nack_q      <= 1'b0;
      last_q      <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (pop) begin
        phase_q   <= phase_d;
        quarter_q <= quarter_d;
        tick_q    <= tick_d;
        bit_q     <= bit_d;
        shift_q   <= shift_d;
        wait_q    <= wait_d;
        addr_q    <= addr_d;
        data_q    <= data_d;
        is_read_q <= is_read_d;
        nack_q    <= nack_d;
        last_q    <= last_d;
        res_q     <= res_d;
      end
      if (item_ready_o) begin
        res_valid_q <= item_valid_i;
      end
    end
  end

  `I2CEE_ASSERT_IMP(a_bit_range, clk_i, rst_ni, 1'b1, bit_q < 4'd8, "bit counter out of range")
  `I2CEE_ASSERT_IMP(a_idle_clear, clk_i, rst_ni, phase_q == PH_IDLE, quarter_q == 2'd0 && tick_q == '0, "idle with timing left over")
  `I2CEE_ASSERT_NXT(a_hold_state, clk_i, rst_ni, !pop, $stable(phase_q) && $stable(tick_q), "state moved without a beat")

endmodule

FILE: verif/tb_i2c_eeprom_byte_master.sv
// Self-checking testbench for the I2C EEPROM byte master: tick stream against a bus predictor
module tb_i2c_eeprom_byte_master;
  import i2cee_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int DIRECTED_ROWS = 14;

  localparam res_t RES_IDLE  = '{1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1};
  localparam res_t RES_START = '{1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1};

  typedef enum logic [3:0] {
    BUS_IDLE, BUS_START, BUS_DEVW, BUS_DEVW_ACK, BUS_MEM, BUS_MEM_ACK, BUS_DATA,
    BUS_DATA_ACK, BUS_RESTART, BUS_DEVR, BUS_DEVR_ACK, BUS_READ, BUS_NOACK, BUS_STOP,
    BUS_WAIT
  } bus_phase_e;

  typedef struct {
    logic        cfg_en;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_val;
    logic [1:0]  cmd;
    logic [7:0]  addr;
    logic [7:0]  data;
    logic        sda;
    logic        typed;
    res_t        want;
  } step_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = CMD_NONE;  // cmd[1:0]
  logic [23:0] s_axis_tdata = '0;        // mem_addr[7:0], write_data[15:8], sda_in[16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;             // scl, sda, busy, read_data[10:3], done, nack
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_eeprom_byte_master dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predictor state
  cfg_t       cfg_now = '{DEVICE_ADDRESS_RST, QUARTER_TICKS_RST, WRITE_WAIT_RST};
  bus_phase_e bus_ph = BUS_IDLE;
  int         bit_cnt = 0;
  logic [7:0] shreg = '0;
  logic [1:0] qtr = '0;
  logic [15:0] tick_cnt = '0;
  logic [19:0] wait_cnt = '0;
  logic [7:0] held_addr = '0;
  logic [7:0] held_data = '0;
  logic       rd_flag = 1'b0;
  logic       nack_flag = 1'b0;
  logic [7:0] last_read = '0;

  res_t       pending_levels[$];
  int         src_idle_pct = 0;
  int         sink_idle_pct = 0;
  logic       reads_only = 1'b0;
  int         errors = 0;
  int         beats_in = 0;
  int         beats_checked = 0;
  int         reads_done = 0;
  int         writes_done = 0;
  int         nacked = 0;
  int         reg_writes = 0;
  int         stall_cycles = 0;
  step_row_t  plan [DIRECTED_ROWS];

  function automatic res_t master_tick(item_t it);
    res_t        r;
    logic [15:0] per;
    logic        fin;
    r = '0;
    r.scl_out = 1'b1;
    r.sda_out = 1'b1;
    fin = 1'b0;
    if (bus_ph == BUS_IDLE && (it.kind == KIND_WRITE || it.kind == KIND_READ)) begin
      held_addr = it.mem_addr;
      held_data = it.write_data;
      rd_flag = (it.kind == KIND_READ);
      nack_flag = 1'b0;
      bus_ph = BUS_START;
      qtr = '0;
      tick_cnt = '0;
      bit_cnt = 0;
    end
    case (bus_ph)
      BUS_IDLE, BUS_WAIT: ;
      BUS_START: begin
        r.scl_out = (qtr != 2'd3);
        r.sda_out = (qtr < 2'd2);
      end
      BUS_RESTART: begin
        r.scl_out = (qtr == 2'd1 || qtr == 2'd2);
        r.sda_out = (qtr < 2'd2);
      end
      BUS_STOP: begin
        r.scl_out = (qtr != 2'd0);
        r.sda_out = (qtr >= 2'd2);
      end
      BUS_DEVW, BUS_MEM, BUS_DATA, BUS_DEVR: begin
        r.scl_out = (qtr == 2'd1 || qtr == 2'd2);
        r.sda_out = shreg[7];
      end
      default: begin
        r.scl_out = (qtr == 2'd1 || qtr == 2'd2);
      end
    endcase
    if (bus_ph != BUS_IDLE) begin
      per = (cfg_now.quarter_period_ticks == '0) ? 16'd1 : cfg_now.quarter_period_ticks;
      if (int'(tick_cnt) + 1 >= int'(per)) begin
        tick_cnt = '0;
        if (bus_ph == BUS_WAIT) begin
          wait_cnt = wait_cnt - 20'd1;
          fin = (wait_cnt == '0);
        end else begin
          if (qtr == 2'd2) begin
            if (bus_ph inside {BUS_DEVW_ACK, BUS_MEM_ACK, BUS_DATA_ACK, BUS_DEVR_ACK})
              nack_flag = nack_flag | it.sda_in;
            else if (bus_ph == BUS_READ)
              shreg = {shreg[6:0], it.sda_in};
          end
          if (qtr < 2'd3) begin
            qtr = qtr + 2'd1;
          end else begin
            qtr = '0;
            case (bus_ph)
              BUS_START: begin
                bus_ph = BUS_DEVW;
                shreg = {cfg_now.device_address, 1'b0};
                bit_cnt = 0;
              end
              BUS_DEVW, BUS_MEM, BUS_DATA, BUS_DEVR: begin
                shreg = shreg << 1;
                bit_cnt++;
                if (bit_cnt >= 8) begin
                  bit_cnt = 0;
                  bus_ph = bus_phase_e'(bus_ph + 4'd1);
                end
              end
              BUS_DEVW_ACK: begin
                bus_ph = BUS_MEM;
                shreg = held_addr;
                bit_cnt = 0;
              end
              BUS_MEM_ACK: begin
                if (rd_flag) begin
                  bus_ph = BUS_RESTART;
                end else begin
                  bus_ph = BUS_DATA;
                  shreg = held_data;
                  bit_cnt = 0;
                end
              end
              BUS_DATA_ACK, BUS_NOACK: bus_ph = BUS_STOP;
              BUS_RESTART: begin
                bus_ph = BUS_DEVR;
                shreg = {cfg_now.device_address, 1'b1};
                bit_cnt = 0;
              end
              BUS_DEVR_ACK: begin
                bus_ph = BUS_READ;
                shreg = '0;
                bit_cnt = 0;
              end
              BUS_READ: begin
                bit_cnt++;
                if (bit_cnt >= 8) begin
                  bit_cnt = 0;
                  bus_ph = BUS_NOACK;
                end
              end
              BUS_STOP: begin
                if (rd_flag) begin
                  last_read = shreg;
                  fin = 1'b1;
                end else if (cfg_now.write_wait_quarters == '0) begin
                  fin = 1'b1;
                end else begin
                  wait_cnt = cfg_now.write_wait_quarters;
                  bus_ph = BUS_WAIT;
                end
              end
              default: fin = 1'b1;
            endcase
          end
        end
        if (fin) begin
          bus_ph = BUS_IDLE;
          qtr = '0;
          tick_cnt = '0;
        end
      end else begin
        tick_cnt = tick_cnt + 16'd1;
      end
    end
    r.busy_res = (bus_ph != BUS_IDLE);
    r.read_data = last_read;
    r.done_res = fin;
    r.nack_seen = nack_flag;
    return r;
  endfunction

  function automatic item_t random_tick();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(99);
    it.mem_addr = 8'($urandom_range(255));
    it.write_data = 8'($urandom_range(255));
    if (bus_ph == BUS_IDLE) begin
      if (pick < 10) it.kind = kind_e'(CMD_NONE);
      else if (pick < 20) it.kind = kind_e'(CMD_UNUSED);
      else if (reads_only || pick < 60) it.kind = KIND_READ;
      else it.kind = KIND_WRITE;
    end else begin
      it.kind = kind_e'($urandom_range(3));
    end
    // mostly acknowledge, now and then miss
    if (bus_ph inside {BUS_DEVW_ACK, BUS_MEM_ACK, BUS_DATA_ACK, BUS_DEVR_ACK})
      it.sda_in = ($urandom_range(9) == 0);
    else
      it.sda_in = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  task automatic push_tick(input item_t it, input logic typed, input res_t want);
    res_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.kind;
    s_axis_tdata <= {7'd0, it.sda_in, it.write_data, it.mem_addr};
    do @(posedge clk_i); while (!s_axis_tready);
    r = master_tick(it);
    pending_levels.push_back(typed ? want : r);
    beats_in++;
    if (r.done_res) begin
      if (rd_flag) reads_done++;
      else writes_done++;
      if (r.nack_seen) nacked++;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] want;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DEVICE_ADDRESS: cfg_now.device_address = val[6:0];
      REG_QUARTER_TICKS: cfg_now.quarter_period_ticks = val[15:0];
      REG_WRITE_WAIT: cfg_now.write_wait_quarters = val[19:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_DEVICE_ADDRESS: want = {25'd0, cfg_now.device_address};
      REG_QUARTER_TICKS: want = {16'd0, cfg_now.quarter_period_ticks};
      default: want = {12'd0, cfg_now.write_wait_quarters};
    endcase
    if (prdata !== want) begin
      $display("%0t: register %0d readback, expected %0h, actual %0h", $time, idx, want,
               prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[12:0]);
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %0h", $time, got);
        errors++;
      end else begin
        want = pending_levels.pop_front();
        check_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
        check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
        check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        check_field("read_data", want.read_data, got.read_data);
        check_field("done_res", 8'(want.done_res), 8'(got.done_res));
        check_field("nack_seen", 8'(want.nack_seen), 8'(got.nack_seen));
        beats_checked++;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    item_t it;
    plan = '{
      '{1'b0, REG_DEVICE_ADDRESS, 32'd0, CMD_NONE,   8'hff, 8'hff, 1'b1, 1'b1, RES_IDLE},
      '{1'b0, REG_DEVICE_ADDRESS, 32'd0, CMD_UNUSED, 8'h00, 8'h00, 1'b0, 1'b1, RES_IDLE},
      '{1'b0, REG_DEVICE_ADDRESS, 32'd0, CMD_WRITE,  8'h00, 8'hff, 1'b1, 1'b1, RES_START},
      '{1'b0, REG_DEVICE_ADDRESS, 32'd0, CMD_READ,   8'hff, 8'h00, 1'b0, 1'b1, RES_START},
      '{1'b0, REG_DEVICE_ADDRESS, 32'd0, CMD_NONE,   8'h5a, 8'ha5, 1'b1, 1'b0, RES_IDLE},
      '{1'b1, REG_QUARTER_TICKS, 32'hffff, CMD_NONE, 8'ha5, 8'h5a, 1'b0, 1'b0, RES_IDLE},
      '{1'b0, REG_DEVICE_ADDRESS, 32'd0, CMD_NONE,   8'hff, 8'h00, 1'b1, 1'b0, RES_IDLE},
      '{1'b1, REG_WRITE_WAIT,     32'd0, CMD_NONE,   8'h00, 8'hff, 1'b0, 1'b0, RES_IDLE},
      '{1'b1, REG_DEVICE_ADDRESS, 32'd0, CMD_NONE,   8'h0f, 8'hf0, 1'b1, 1'b0, RES_IDLE},
      '{1'b1, REG_QUARTER_TICKS,  32'd0, CMD_NONE,   8'hf0, 8'h0f, 1'b0, 1'b0, RES_IDLE},
      '{1'b0, REG_DEVICE_ADDRESS, 32'd0, CMD_READ,   8'h33, 8'hcc, 1'b1, 1'b0, RES_IDLE},
      '{1'b0, REG_DEVICE_ADDRESS, 32'd0, CMD_UNUSED, 8'hcc, 8'h33, 1'b0, 1'b0, RES_IDLE},
      '{1'b0, REG_DEVICE_ADDRESS, 32'd0, CMD_NONE,   8'h00, 8'h00, 1'b1, 1'b0, RES_IDLE},
      '{1'b0, REG_DEVICE_ADDRESS, 32'd0, CMD_WRITE,  8'hff, 8'hff, 1'b0, 1'b0, RES_IDLE}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 36;
    sink_idle_pct = 77;
    foreach (plan[i]) begin
      if (plan[i].cfg_en) begin
        drain();
        reg_write(plan[i].cfg_idx, plan[i].cfg_val);
      end
      it.kind = kind_e'(plan[i].cmd);
      it.mem_addr = plan[i].addr;
      it.write_data = plan[i].data;
      it.sda_in = plan[i].sda;
      push_tick(it, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < 3; p++) begin
      while (bus_ph != BUS_IDLE) push_tick(random_tick(), 1'b0, RES_IDLE);
      drain();
      case (p)
        0: begin
          reg_write(REG_DEVICE_ADDRESS, 32'd127);
          reg_write(REG_QUARTER_TICKS, 32'd1);
          reg_write(REG_WRITE_WAIT, 32'($urandom_range(1, 20)));
        end
        1: begin
          // long write cycle: reads only while it is set
          reg_write(REG_DEVICE_ADDRESS, 32'($urandom_range(127)));
          reg_write(REG_WRITE_WAIT, 32'hfffff);
          src_idle_pct = 77;
          sink_idle_pct = 36;
          reads_only = 1'b1;
        end
        default: begin
          reg_write(REG_DEVICE_ADDRESS, 32'(DEVICE_ADDRESS_RST));
          reg_write(REG_QUARTER_TICKS, 32'd2);
          reg_write(REG_WRITE_WAIT, 32'($urandom_range(0, 30)));
          src_idle_pct = 0;
          sink_idle_pct = 0;
          reads_only = 1'b0;
        end
      endcase
      repeat (ITEMS_PER_PHASE) push_tick(random_tick(), 1'b0, RES_IDLE);
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Ticks sent %0d, checked %0d, register writes %0d", beats_in, beats_checked,
             reg_writes);
    $display("Bus transfers finished: %0d reads, %0d writes, %0d with a missed acknowledge",
             reads_done, writes_done, nacked);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
